/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dispatch queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, ck, rn, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (expr)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (pre) |-> (post)) \
    else $error(msg);

`endif

/* hw/rtl/tedq_pkg.sv */
// ----------------------------------------------------------------------------
// tedq_pkg
// Types, constants and helpers shared by the timed event dispatch queue.
// ----------------------------------------------------------------------------
package tedq_pkg;

  localparam int POOL_ENTRIES = 32;
  localparam int TIME_BITS    = 24;
  localparam int IDX_W        = $clog2(POOL_ENTRIES);
  localparam int HANDLE_W     = 16;
  localparam int FUNC_W       = 2;
  localparam int STATUS_W     = 3;
  localparam int DELAY_W      = 8;

  localparam logic [DELAY_W-1:0]   DELAY_RESET = DELAY_W'(3);
  // Half the time span minus one: the wraparound "later" window
  localparam logic [TIME_BITS-1:0] HALF_SPAN   = {1'b0, {(TIME_BITS-1){1'b1}}};

  typedef enum logic [FUNC_W-1:0] {
    FN_TIMED = 2'd0,
    FN_IDLE  = 2'd1,
    FN_TAKE  = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED = 3'd0,
    STS_DROPPED  = 3'd1,
    STS_TIMED    = 3'd2,
    STS_IDLE     = 3'd3,
    STS_NONE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_DISPATCH,
    CS_POP_FREE,
    CS_WALK_LINK,
    CS_WALK_CMP,
    CS_WALK_FIX,
    CS_TAKE,
    CS_TAKE_IDLE,
    CS_CMP_RD,
    CS_DONE
  } state_t;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_DROP,
    OP_ALLOC,
    OP_IDLE_PUSH,
    OP_TIMED_FIRST,
    OP_TIMED_HEAD,
    OP_WALK_START,
    OP_APPEND_BEFORE,
    OP_WALK_FIRST,
    OP_WALK_ADV,
    OP_APPEND_CUR,
    OP_LINK_E,
    OP_FIX,
    OP_TAKE_RD,
    OP_TAKE_TIMED,
    OP_TAKE_IDLE_RD,
    OP_TAKE_IDLE,
    OP_CMP_RD,
    OP_PUBLISH
  } dp_op_t;

  // Datapath status toward the controller
  typedef struct packed {
    func_t func;
    logic  free_ne;
    logic  timed_ne;
    logic  idle_ne;
    logic  before_is_tail;
    logic  cur_is_tail;
    logic  due_after_ts;
    logic  due_reached;
    logic  out_free;
  } dp_stat_t;

  // a is later than or equal to b under wraparound
  function automatic logic is_latter(input logic [TIME_BITS-1:0] a,
                                     input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] diff;
    diff = a - b;
    return diff < HALF_SPAN;
  endfunction

  // Link value of an entry after reset: next index, last wraps to zero
  function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(POOL_ENTRIES - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

/* hw/rtl/tedq_ram.sv */
// ----------------------------------------------------------------------------
// tedq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tedq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and read old data on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tedq_ctrl.sv */
// ----------------------------------------------------------------------------
// tedq_ctrl
// Controller state machine: sequences one transaction through the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tedq_ctrl
  import tedq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  state_t state_r;
  state_t state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          state_nxt = CS_DISPATCH;
        end
      end
      CS_DISPATCH: begin
        unique case (stat.func) inside
          FN_TIMED, FN_IDLE: begin
            state_nxt = stat.free_ne ? CS_POP_FREE : CS_CMP_RD;
          end
          FN_TAKE: begin
            state_nxt = CS_TAKE;
          end
          default: begin
            state_nxt = CS_CMP_RD;
          end
        endcase
      end
      CS_POP_FREE: begin
        if (stat.func == FN_IDLE || !stat.timed_ne || stat.due_after_ts) begin
          state_nxt = CS_CMP_RD;
        end else begin
          state_nxt = CS_WALK_LINK;
        end
      end
      CS_WALK_LINK: begin
        state_nxt = stat.before_is_tail ? CS_CMP_RD : CS_WALK_CMP;
      end
      CS_WALK_CMP: begin
        if (stat.due_after_ts) begin
          state_nxt = CS_WALK_FIX;
        end else if (stat.cur_is_tail) begin
          state_nxt = CS_CMP_RD;
        end
      end
      CS_WALK_FIX: begin
        state_nxt = CS_CMP_RD;
      end
      CS_TAKE: begin
        if (!(stat.timed_ne && stat.due_reached) && stat.idle_ne) begin
          state_nxt = CS_TAKE_IDLE;
        end else begin
          state_nxt = CS_CMP_RD;
        end
      end
      CS_TAKE_IDLE: begin
        state_nxt = CS_CMP_RD;
      end
      CS_CMP_RD: begin
        state_nxt = CS_DONE;
      end
      CS_DONE: begin
        if (stat.out_free) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // Datapath commands
  always_comb begin
    op = OP_NONE;
    unique case (state_r)
      CS_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
        end
      end
      CS_DISPATCH: begin
        unique case (stat.func) inside
          FN_TIMED, FN_IDLE: begin
            op = stat.free_ne ? OP_ALLOC : OP_DROP;
          end
          FN_TAKE: begin
            op = OP_TAKE_RD;
          end
          default: begin
            op = OP_NONE;
          end
        endcase
      end
      CS_POP_FREE: begin
        if (stat.func == FN_IDLE) begin
          op = OP_IDLE_PUSH;
        end else if (!stat.timed_ne) begin
          op = OP_TIMED_FIRST;
        end else if (stat.due_after_ts) begin
          op = OP_TIMED_HEAD;
        end else begin
          op = OP_WALK_START;
        end
      end
      CS_WALK_LINK: begin
        op = stat.before_is_tail ? OP_APPEND_BEFORE : OP_WALK_FIRST;
      end
      CS_WALK_CMP: begin
        if (stat.due_after_ts) begin
          op = OP_LINK_E;
        end else if (stat.cur_is_tail) begin
          op = OP_APPEND_CUR;
        end else begin
          op = OP_WALK_ADV;
        end
      end
      CS_WALK_FIX: begin
        op = OP_FIX;
      end
      CS_TAKE: begin
        if (stat.timed_ne && stat.due_reached) begin
          op = OP_TAKE_TIMED;
        end else if (stat.idle_ne) begin
          op = OP_TAKE_IDLE_RD;
        end
      end
      CS_TAKE_IDLE: begin
        op = OP_TAKE_IDLE;
      end
      CS_CMP_RD: begin
        op = OP_CMP_RD;
      end
      CS_DONE: begin
        if (stat.out_free) begin
          op = OP_PUBLISH;
        end
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  assign in_stall = (state_r != CS_IDLE);

  // The walk only runs over a nonempty timed queue
  `ASSERT_IMPLIES(a_walk_nonempty, clk, rst_n, state_r == CS_WALK_CMP, stat.timed_ne,
                  "sorted walk with empty timed queue")

endmodule

/* hw/rtl/tedq_dp.sv */
// ----------------------------------------------------------------------------
// tedq_dp
// Datapath: entry memories, queue pointers, walk cursor and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tedq_dp
  import tedq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_op_t                op,
  output dp_stat_t              stat,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic [TIME_BITS-1:0]  in_timestamp,
  input  logic [TIME_BITS-1:0]  in_now,
  input  logic                  cfg_wr_en,
  input  logic [DELAY_W-1:0]    cfg_wr_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [HANDLE_W-1:0]   out_job_handle,
  output logic [TIME_BITS-1:0]  out_compare_value
);

  // Latched transaction
  func_t                 func_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [TIME_BITS-1:0]  ts_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [DELAY_W-1:0]    min_delay_r;

  // Queue pointers
  logic [IDX_W-1:0] free_head_r, free_tail_r;
  logic             free_ne_r;
  logic [IDX_W-1:0] timed_head_r, timed_tail_r;
  logic             timed_ne_r;
  logic [IDX_W-1:0] idle_head_r, idle_tail_r;
  logic             idle_ne_r;

  // Work registers
  logic [IDX_W-1:0]    e_r;
  logic [IDX_W-1:0]    before_r;
  logic [IDX_W-1:0]    cur_r;
  status_t             status_r;
  logic [HANDLE_W-1:0] jh_r;

  // Result register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [HANDLE_W-1:0]  out_jh_r;
  logic [TIME_BITS-1:0] out_cmp_r;

  // Link valid bits and read tracking
  logic [POOL_ENTRIES-1:0] lvalid_r;
  logic [IDX_W-1:0]        lrd_addr_r;
  logic                    lrd_valid_r;

  // Memory ports
  logic                 hnd_we, hnd_re;
  logic [IDX_W-1:0]     hnd_raddr;
  logic [HANDLE_W-1:0]  hnd_q;
  logic                 due_we, due_re;
  logic [IDX_W-1:0]     due_raddr;
  logic [TIME_BITS-1:0] due_wdata, due_q;
  logic                 link_we, link_re;
  logic [IDX_W-1:0]     link_waddr, link_wdata, link_raddr, link_q, link_rd;

  logic [TIME_BITS-1:0] near_t;
  logic [TIME_BITS-1:0] cmp_val;
  logic                 out_free;
  logic                 pop_free;

  tedq_ram #(.WIDTH(HANDLE_W), .DEPTH(POOL_ENTRIES)) u_hnd_ram (
    .clk   (clk),
    .we    (hnd_we),
    .waddr (free_head_r),
    .wdata (handle_r),
    .re    (hnd_re),
    .raddr (hnd_raddr),
    .rdata (hnd_q)
  );

  tedq_ram #(.WIDTH(TIME_BITS), .DEPTH(POOL_ENTRIES)) u_due_ram (
    .clk   (clk),
    .we    (due_we),
    .waddr (free_head_r),
    .wdata (due_wdata),
    .re    (due_re),
    .raddr (due_raddr),
    .rdata (due_q)
  );

  tedq_ram #(.WIDTH(IDX_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (link_raddr),
    .rdata (link_q)
  );

  // Unwritten links read as their reset chain
  assign link_rd = lrd_valid_r ? link_q : link_reset(lrd_addr_r);

  // Fill entry on allocation
  assign hnd_we    = (op == OP_ALLOC);
  assign due_we    = (op == OP_ALLOC);
  assign due_wdata = (func_r == FN_TIMED) ? ts_r : '0;

  // Decode memory reads and link writes
  always_comb begin
    hnd_re     = 1'b0;
    hnd_raddr  = timed_head_r;
    due_re     = 1'b0;
    due_raddr  = timed_head_r;
    link_re    = 1'b0;
    link_raddr = timed_head_r;
    link_we    = 1'b0;
    link_waddr = e_r;
    link_wdata = e_r;
    unique case (op) inside
      OP_ALLOC: begin
        link_re    = 1'b1;
        link_raddr = free_head_r;
        due_re     = 1'b1;
      end
      OP_TAKE_RD: begin
        link_re = 1'b1;
        due_re  = 1'b1;
        hnd_re  = 1'b1;
      end
      OP_TAKE_IDLE_RD: begin
        link_re    = 1'b1;
        link_raddr = idle_head_r;
        hnd_re     = 1'b1;
        hnd_raddr  = idle_head_r;
      end
      OP_WALK_START: begin
        link_re = 1'b1;
      end
      OP_WALK_FIRST, OP_WALK_ADV: begin
        link_re    = 1'b1;
        link_raddr = link_rd;
        due_re     = 1'b1;
        due_raddr  = link_rd;
      end
      OP_CMP_RD: begin
        due_re = 1'b1;
      end
      OP_IDLE_PUSH: begin
        link_we    = idle_ne_r;
        link_waddr = idle_tail_r;
      end
      OP_TIMED_HEAD: begin
        link_we    = 1'b1;
        link_wdata = timed_head_r;
      end
      OP_APPEND_BEFORE, OP_FIX: begin
        link_we    = 1'b1;
        link_waddr = before_r;
      end
      OP_APPEND_CUR: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
      end
      OP_LINK_E: begin
        link_we    = 1'b1;
        link_wdata = cur_r;
      end
      OP_TAKE_TIMED: begin
        link_we    = free_ne_r;
        link_waddr = free_tail_r;
        link_wdata = timed_head_r;
      end
      OP_TAKE_IDLE: begin
        link_we    = free_ne_r;
        link_waddr = free_tail_r;
        link_wdata = idle_head_r;
      end
      default: begin
      end
    endcase
  end

  assign pop_free = (op == OP_IDLE_PUSH) || (op == OP_TIMED_FIRST) ||
                    (op == OP_TIMED_HEAD) || (op == OP_WALK_START);

  // Compare value from the state after the transaction
  always_comb begin
    near_t = now_r + TIME_BITS'(min_delay_r);
    if (!timed_ne_r) begin
      cmp_val = now_r - 1'b1;
    end else if (is_latter(due_q, near_t)) begin
      cmp_val = due_q;
    end else begin
      cmp_val = near_t;
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Control state: queue pointers, link valid bits, register, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r  <= '0;
      free_tail_r  <= IDX_W'(POOL_ENTRIES - 1);
      free_ne_r    <= 1'b1;
      timed_head_r <= '0;
      timed_tail_r <= '0;
      timed_ne_r   <= 1'b0;
      idle_head_r  <= '0;
      idle_tail_r  <= '0;
      idle_ne_r    <= 1'b0;
      lvalid_r     <= '0;
      min_delay_r  <= DELAY_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        min_delay_r <= cfg_wr_data;
      end
      if (link_we) begin
        lvalid_r[link_waddr] <= 1'b1;
      end

      // Pop the free head
      if (pop_free) begin
        if (free_head_r == free_tail_r) begin
          free_ne_r <= 1'b0;
        end else begin
          free_head_r <= link_rd;
        end
      end

      // Return a taken entry to the free tail
      if (op == OP_TAKE_TIMED || op == OP_TAKE_IDLE) begin
        if (free_ne_r) begin
          free_tail_r <= (op == OP_TAKE_TIMED) ? timed_head_r : idle_head_r;
        end else begin
          free_head_r <= (op == OP_TAKE_TIMED) ? timed_head_r : idle_head_r;
          free_tail_r <= (op == OP_TAKE_TIMED) ? timed_head_r : idle_head_r;
          free_ne_r   <= 1'b1;
        end
      end

      // Timed queue updates
      case (op)
        OP_TIMED_FIRST: begin
          timed_head_r <= e_r;
          timed_tail_r <= e_r;
          timed_ne_r   <= 1'b1;
        end
        OP_TIMED_HEAD: begin
          timed_head_r <= e_r;
        end
        OP_APPEND_BEFORE, OP_APPEND_CUR: begin
          timed_tail_r <= e_r;
        end
        OP_TAKE_TIMED: begin
          if (timed_head_r == timed_tail_r) begin
            timed_ne_r <= 1'b0;
          end else begin
            timed_head_r <= link_rd;
          end
        end
        default: begin
        end
      endcase

      // Idle queue updates
      if (op == OP_IDLE_PUSH) begin
        if (idle_ne_r) begin
          idle_tail_r <= e_r;
        end else begin
          idle_head_r <= e_r;
          idle_tail_r <= e_r;
          idle_ne_r   <= 1'b1;
        end
      end else if (op == OP_TAKE_IDLE) begin
        if (idle_head_r == idle_tail_r) begin
          idle_ne_r <= 1'b0;
        end else begin
          idle_head_r <= link_rd;
        end
      end

      // Hold result until taken
      if (op == OP_PUBLISH) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: latched fields, cursor, result
  always_ff @(posedge clk) begin
    if (link_re) begin
      lrd_addr_r  <= link_raddr;
      lrd_valid_r <= lvalid_r[link_raddr];
    end
    case (op)
      OP_LOAD: begin
        func_r   <= func_t'(in_func);
        handle_r <= in_handle;
        ts_r     <= in_timestamp;
        now_r    <= in_now;
        status_r <= STS_NONE;
        jh_r     <= '0;
      end
      OP_DROP: begin
        status_r <= STS_DROPPED;
      end
      OP_ALLOC: begin
        e_r      <= free_head_r;
        status_r <= STS_INSERTED;
      end
      OP_WALK_START: begin
        before_r <= timed_head_r;
      end
      OP_WALK_FIRST: begin
        cur_r <= link_rd;
      end
      OP_WALK_ADV: begin
        before_r <= cur_r;
        cur_r    <= link_rd;
      end
      OP_TAKE_TIMED: begin
        jh_r     <= hnd_q;
        status_r <= STS_TIMED;
      end
      OP_TAKE_IDLE: begin
        jh_r     <= hnd_q;
        status_r <= STS_IDLE;
      end
      OP_PUBLISH: begin
        out_status_r <= status_r;
        out_jh_r     <= jh_r;
        out_cmp_r    <= cmp_val;
      end
      default: begin
      end
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.func           = func_r;
    stat.free_ne        = free_ne_r;
    stat.timed_ne       = timed_ne_r;
    stat.idle_ne        = idle_ne_r;
    stat.before_is_tail = (before_r == timed_tail_r);
    stat.cur_is_tail    = (cur_r == timed_tail_r);
    stat.due_after_ts   = is_latter(due_q, ts_r);
    stat.due_reached    = is_latter(now_r, due_q);
    stat.out_free       = out_free;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_job_handle    = out_jh_r;
  assign out_compare_value = out_cmp_r;

  // Entries never vanish: an empty pool means some queue holds them
  `ASSERT_ALWAYS(a_pool_not_lost, clk, rst_n, free_ne_r || timed_ne_r || idle_ne_r,
                 "all three lists empty")

  // Never overwrite a result that is still stalled
  `ASSERT_IMPLIES(a_publish_free, clk, rst_n, op == OP_PUBLISH,
                  !out_valid_r || !out_stall, "result overwritten while stalled")

endmodule

/* hw/rtl/timed_event_dispatch_queue.sv */
// ----------------------------------------------------------------------------
// timed_event_dispatch_queue
// Event scheduler with a shared entry pool, a sorted timed queue and an idle
// FIFO, returning one result with the next wake-up compare value per request.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Each passes through DISPATCH, the
// states of its kind, CMP_RD and DONE, which publishes the result. A
// dropped insert or an unused code adds no state, an idle insert adds
// POP_FREE, a take adds TAKE, and a take that hands out an idle job also
// TAKE_IDLE. A timed insert adds POP_FREE and, unless the timed queue is
// empty or it goes before the head, WALK_LINK, WALK_CMP per entry it
// compares and WALK_FIX when it links in mid-queue. The sorted walk steps
// the link and due-time memories one entry per cycle. A new transaction
// can be accepted in the same cycle that the result is presented. The
// result sits in an output register, so a new transaction is accepted
// while the previous result is still stalled; a second one waits until
// that result is taken. min_delay may be written whenever no transaction
// is in flight; it resets to 3. No clearing pass runs after reset.
module timed_event_dispatch_queue
  import tedq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic [TIME_BITS-1:0]  in_timestamp,
  input  logic [TIME_BITS-1:0]  in_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [HANDLE_W-1:0]   out_job_handle,
  output logic [TIME_BITS-1:0]  out_compare_value,
  input  logic                  cfg_wr_en,
  input  logic [DELAY_W-1:0]    cfg_wr_data
);

  dp_op_t   op;
  dp_stat_t stat;

  // Sequence each transaction
  tedq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // Hold queues, entries and result
  tedq_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_timestamp      (in_timestamp),
    .in_now            (in_now),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_job_handle    (out_job_handle),
    .out_compare_value (out_compare_value)
  );

endmodule
